>>> src/psrc_pkg.sv
// types, constants and crc function shared by the packet reassembly block
`timescale 1ns / 1ps
package psrc_pkg;

	localparam int POS_W = 5;
	localparam int NUM_W = 5;
	localparam int FRAME_W = 6;
	localparam int CRC_W = 16;

	localparam logic [CRC_W-1:0] CRC_POLY_REFLECTED = 16'h8408;
	localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
	localparam logic [CRC_W-1:0] CRC_XOROUT = 16'hFFFF;
	localparam logic [CRC_W-1:0] CRC_GOOD = 16'h0F47;
	localparam logic [FRAME_W-1:0] FRAME_MAX = 6'd63;
	localparam int LAST_BIT = 7;

	typedef enum logic [1:0] {
		STATUS_APPENDED = 2'd0,
		STATUS_CRC_GOOD = 2'd1,
		STATUS_CRC_ERROR = 2'd2,
		STATUS_SEQ_ERROR = 2'd3
	} status_t;

	typedef struct packed {
		logic clear_packet;
		logic [7:0] seg_byte;
	} item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [CRC_W-1:0] packet_check;
		logic [NUM_W-1:0] segment_number;
	} result_t;

	function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc,
		input logic [7:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY_REFLECTED;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

>>> src/psrc_core.sv
// segment state, per-byte crc snapshots and result computation
`timescale 1ns / 1ps
module psrc_core #(
	parameter int SEGMENT_DATA_BYTES = 25
) (
	input  logic clk,
	input  logic arst_n,
	input  logic accept,
	input  psrc_pkg::item_t item,
	output logic res_valid,
	output psrc_pkg::result_t res
);

	localparam int IDX_W = (SEGMENT_DATA_BYTES > 1) ? $clog2(SEGMENT_DATA_BYTES) : 1;
	localparam logic [psrc_pkg::POS_W-1:0] SDB = psrc_pkg::POS_W'(SEGMENT_DATA_BYTES);

	logic [psrc_pkg::CRC_W-1:0] committed_crc_q;
	logic [psrc_pkg::CRC_W-1:0] tentative_crc_q;
	logic [psrc_pkg::CRC_W-1:0] crc_after_byte_q [SEGMENT_DATA_BYTES];
	logic [psrc_pkg::FRAME_W-1:0] expected_frame_q;
	logic [psrc_pkg::POS_W-1:0] byte_position_q;

	logic is_data;
	logic is_last;
	logic [psrc_pkg::NUM_W-1:0] num;
	logic [psrc_pkg::POS_W-1:0] size;
	logic [psrc_pkg::POS_W-1:0] size_m1;
	logic [psrc_pkg::CRC_W-1:0] fold;
	logic [psrc_pkg::CRC_W-1:0] last_crc;
	logic [psrc_pkg::CRC_W-1:0] check;
	logic seq_ok;
	logic [psrc_pkg::CRC_W-1:0] committed_next;

	assign is_data = byte_position_q < SDB;
	assign num = item.seg_byte[6:2];
	assign is_last = item.seg_byte[psrc_pkg::LAST_BIT];
	assign size = (num > SDB) ? SDB : num;
	assign size_m1 = size - psrc_pkg::POS_W'(1);
	assign fold = psrc_pkg::crc_fold(tentative_crc_q, item.seg_byte);
	assign seq_ok = {1'b0, num} == expected_frame_q;

	always_comb begin
		if (size == '0) begin
			last_crc = committed_crc_q;
		end else begin
			last_crc = crc_after_byte_q[size_m1[IDX_W-1:0]];
		end
		check = last_crc ^ psrc_pkg::CRC_XOROUT;
		res.segment_number = num;
		if (is_last) begin
			committed_next = last_crc;
			res.packet_check = check;
			res.status = (check == psrc_pkg::CRC_GOOD) ? psrc_pkg::STATUS_CRC_GOOD
				: psrc_pkg::STATUS_CRC_ERROR;
		end else if (!seq_ok) begin
			committed_next = committed_crc_q;
			res.packet_check = '0;
			res.status = psrc_pkg::STATUS_SEQ_ERROR;
		end else begin
			committed_next = tentative_crc_q;
			res.packet_check = '0;
			res.status = psrc_pkg::STATUS_APPENDED;
		end
	end

	assign res_valid = accept && !item.clear_packet && !is_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			committed_crc_q <= psrc_pkg::CRC_INIT;
			tentative_crc_q <= psrc_pkg::CRC_INIT;
			expected_frame_q <= '0;
			byte_position_q <= '0;
		end else if (accept) begin
			if (item.clear_packet) begin
				committed_crc_q <= psrc_pkg::CRC_INIT;
				tentative_crc_q <= psrc_pkg::CRC_INIT;
				expected_frame_q <= '0;
				byte_position_q <= '0;
			end else if (is_data) begin
				tentative_crc_q <= fold;
				byte_position_q <= byte_position_q + psrc_pkg::POS_W'(1);
			end else begin
				committed_crc_q <= committed_next;
				tentative_crc_q <= committed_next;
				byte_position_q <= '0;
				if (!is_last && seq_ok && expected_frame_q != psrc_pkg::FRAME_MAX) begin
					expected_frame_q <= expected_frame_q + psrc_pkg::FRAME_W'(1);
				end
			end
		end
	end

	// snapshots need no reset, each entry is written before it is read
	always_ff @(posedge clk) begin
		if (accept && !item.clear_packet && is_data) begin
			crc_after_byte_q[byte_position_q[IDX_W-1:0]] <= fold;
		end
	end

endmodule

>>> src/psrc_out_reg.sv
// result register between the core and the result channel
`timescale 1ns / 1ps
module psrc_out_reg (
	input  logic clk,
	input  logic arst_n,
	input  logic res_valid,
	input  psrc_pkg::result_t res,
	output logic load_ok,
	output logic result_valid,
	input  logic result_ready,
	output psrc_pkg::result_t result
);

	logic valid_q;
	psrc_pkg::result_t data_q;

	assign load_ok = !valid_q || result_ready;
	assign result_valid = valid_q;
	assign result = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load_ok) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_ok && res_valid) begin
			data_q <= res;
		end
	end

endmodule

>>> src/packet_segment_reassembly_crc_check.sv
// top level of segment reassembly with crc-16 x.25 packet check
//
//   channel   direction  payload              handshake
//   item      in         psrc_pkg::item_t     item_valid / item_ready
//   result    out        psrc_pkg::result_t   result_valid / result_ready
//
// one byte per cycle while item_ready is high; a control byte gives its result in the cycle after it is taken
// state updates in the cycle of the request, the result sits in one output register
// item_ready is low only while a result is held and result_ready is low
// arst_n clears crc state to 0xffff, frame counter and byte position to zero
`timescale 1ns / 1ps
module packet_segment_reassembly_crc_check #(
	parameter int SEGMENT_DATA_BYTES = 25
) (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_ready,
	input  psrc_pkg::item_t item,
	output logic result_valid,
	input  logic result_ready,
	output psrc_pkg::result_t result
);

	logic accept;
	logic res_valid;
	psrc_pkg::result_t res;

	assign accept = item_valid && item_ready;

	psrc_core #(
		.SEGMENT_DATA_BYTES(SEGMENT_DATA_BYTES)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.item(item),
		.res_valid(res_valid),
		.res(res)
	);

	psrc_out_reg u_out (
		.clk(clk),
		.arst_n(arst_n),
		.res_valid(res_valid),
		.res(res),
		.load_ok(item_ready),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

endmodule

>>> src/psrc_checker.sv
// port checker for the reassembly block and its bind
`timescale 1ns / 1ps
module psrc_checker (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_ready,
	input psrc_pkg::item_t item,
	input logic result_valid,
	input logic result_ready,
	input psrc_pkg::result_t result
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> item_ready)
		else $error("item stalled with empty output");

	a_new_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && ($past(!result_valid) || $past(result_ready))
		|-> $past(item_valid && item_ready && !item.clear_packet))
		else $error("result without a control byte request");

	a_check_field: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |->
		((result.status == psrc_pkg::STATUS_CRC_GOOD
			&& result.packet_check == psrc_pkg::CRC_GOOD)
		|| (result.status == psrc_pkg::STATUS_CRC_ERROR
			&& result.packet_check != psrc_pkg::CRC_GOOD)
		|| ((result.status == psrc_pkg::STATUS_APPENDED
			|| result.status == psrc_pkg::STATUS_SEQ_ERROR)
			&& result.packet_check == '0)))
		else $error("status and checksum disagree");

endmodule

bind packet_segment_reassembly_crc_check psrc_checker u_psrc_checker (.*);

>>> tb/tb_packet_segment_reassembly_crc_check.sv
// testbench for packet segment reassembly: random packets against a crc and sequence tracker
`timescale 1ns / 1ps
module tb_packet_segment_reassembly_crc_check;
	import psrc_pkg::*;

	localparam int SEG_BYTES = 25;
	localparam int STALL_LIMIT = 1000;
	localparam int ITEM_TARGET = 700;
	localparam int CALM_FROM = 300;
	localparam int CALM_TO = 450;

	typedef enum int {
		PKT_GOOD,
		PKT_BAD_CRC,
		PKT_SEQ,
		PKT_TAIL,
		PKT_NOISE,
		PKT_LONG
	} packet_kind_t;

	class packet_crc_tracker;
		logic [CRC_W-1:0] committed;
		logic [CRC_W-1:0] tentative;
		logic [CRC_W-1:0] snapshot [SEG_BYTES];
		logic [FRAME_W-1:0] next_frame;
		int position;
		result_t pending_reports[$];
		int failures;

		function new();
			clear_state();
			failures = 0;
		endfunction

		function void clear_state();
			committed = CRC_INIT;
			tentative = CRC_INIT;
			next_frame = '0;
			position = 0;
		endfunction

		// reflected crc, one input bit at a time
		static function logic [CRC_W-1:0] fold(logic [CRC_W-1:0] crc, logic [7:0] b);
			logic [CRC_W-1:0] c;
			logic fb;
			c = crc;
			for (int i = 0; i < 8; i++) begin
				fb = c[0] ^ b[i];
				c = c >> 1;
				if (fb) begin
					c = c ^ CRC_POLY_REFLECTED;
				end
			end
			return c;
		endfunction

		function void take_byte(item_t it);
			result_t r;
			logic [NUM_W-1:0] num;
			logic [CRC_W-1:0] crc;
			int size;
			if (it.clear_packet) begin
				clear_state();
				return;
			end
			if (position < SEG_BYTES) begin
				tentative = fold(tentative, it.seg_byte);
				snapshot[position] = tentative;
				position++;
				return;
			end
			num = it.seg_byte[6:2];
			r.segment_number = num;
			if (it.seg_byte[LAST_BIT]) begin
				size = (num > SEG_BYTES) ? SEG_BYTES : int'(num);
				crc = (size == 0) ? committed : snapshot[size-1];
				committed = crc;
				r.packet_check = crc ^ CRC_XOROUT;
				r.status = (r.packet_check == CRC_GOOD) ? STATUS_CRC_GOOD
					: STATUS_CRC_ERROR;
			end else if ({1'b0, num} != next_frame) begin
				r.status = STATUS_SEQ_ERROR;
				r.packet_check = '0;
			end else begin
				if (next_frame < FRAME_MAX) begin
					next_frame++;
				end
				committed = tentative;
				r.status = STATUS_APPENDED;
				r.packet_check = '0;
			end
			pending_reports.insert(pending_reports.size(), r);
			position = 0;
			tentative = committed;
		endfunction

		function void check_report(result_t got);
			result_t want;
			if (pending_reports.size() == 0) begin
				if (failures < 10) begin
					$display("unexpected result: status %0d check %h number %0d",
						got.status, got.packet_check, got.segment_number);
				end
				failures++;
				return;
			end
			want = pending_reports.pop_front();
			if (got.status !== want.status || got.packet_check !== want.packet_check ||
				got.segment_number !== want.segment_number) begin
				if (failures < 10) begin
					$display({"mismatch: status exp %0d got %0d, check exp %h got %h,",
						" number exp %0d got %0d"},
						want.status, got.status, want.packet_check, got.packet_check,
						want.segment_number, got.segment_number);
				end
				failures++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	item_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	result_t result;

	packet_crc_tracker tracker = new();
	int items_sent = 0;
	int stalled = 0;
	logic calm;
	logic [7:0] seg_data [SEG_BYTES];

	assign calm = (items_sent >= CALM_FROM) && (items_sent < CALM_TO);

	packet_segment_reassembly_crc_check #(
		.SEGMENT_DATA_BYTES(SEG_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(negedge clk) begin
		result_ready <= calm || ($urandom_range(99) >= 32);
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			tracker.check_report(result);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (result_valid && result_ready)) begin
				stalled <= 0;
			end else begin
				stalled <= stalled + 1;
				if (stalled >= STALL_LIMIT) begin
					$display("FAIL packet_segment_reassembly_crc_check");
					$finish;
				end
			end
		end
	end

	// entered and left at a falling edge
	task automatic send_item(input logic clr, input logic [7:0] b);
		while (!calm && $urandom_range(99) < 32) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= '{clear_packet: clr, seg_byte: b};
		do begin
			@(posedge clk);
		end while (!item_ready);
		tracker.take_byte(item);
		items_sent++;
		@(negedge clk);
	endtask

	function automatic void fill_random();
		for (int i = 0; i < SEG_BYTES; i++) begin
			seg_data[i] = 8'($urandom);
		end
	endfunction

	task automatic send_segment(input logic [7:0] ctrl);
		for (int i = 0; i < SEG_BYTES; i++) begin
			send_item(1'b0, seg_data[i]);
		end
		send_item(1'b0, ctrl);
	endtask

	task automatic run_packet(input packet_kind_t kind);
		int nseg;
		int k;
		int size;
		int bad_seg;
		int pick;
		logic [CRC_W-1:0] run_crc;
		logic [CRC_W-1:0] fcs;
		logic [FRAME_W-1:0] gen_next;
		logic [NUM_W-1:0] frame;
		logic [7:0] ctrl;
		if (kind == PKT_NOISE) begin
			repeat ($urandom_range(1, 80)) begin
				send_item($urandom_range(99) < 5, 8'($urandom));
			end
			return;
		end
		send_item(1'b1, 8'($urandom));
		run_crc = CRC_INIT;
		gen_next = '0;
		if (kind == PKT_LONG) begin
			nseg = 12;
		end else if (kind == PKT_SEQ) begin
			nseg = $urandom_range(1, 3);
		end else begin
			nseg = $urandom_range(0, 3);
		end
		bad_seg = (kind == PKT_SEQ) ? $urandom_range(0, nseg - 1) : -1;
		for (int s = 0; s < nseg; s++) begin
			fill_random();
			frame = s[4:0];
			if (s == bad_seg) begin
				frame = frame + 5'($urandom_range(1, 31));
			end
			if ({1'b0, frame} == gen_next) begin
				gen_next++;
				for (int i = 0; i < SEG_BYTES; i++) begin
					run_crc = packet_crc_tracker::fold(run_crc, seg_data[i]);
				end
			end
			send_segment({1'b0, frame, 2'($urandom)});
		end
		// last segment carries payload then the checksum, low byte first
		fill_random();
		k = $urandom_range(0, SEG_BYTES - 2);
		size = k + 2;
		for (int i = 0; i < k; i++) begin
			run_crc = packet_crc_tracker::fold(run_crc, seg_data[i]);
		end
		fcs = run_crc ^ CRC_XOROUT;
		seg_data[k] = fcs[7:0];
		seg_data[k+1] = fcs[15:8];
		if (kind == PKT_BAD_CRC) begin
			pick = $urandom_range(0, size - 1);
			if ($urandom_range(1) == 1) begin
				seg_data[pick] = seg_data[pick] ^ 8'(1 << $urandom_range(7));
			end else begin
				size = pick;
			end
		end
		send_segment({1'b1, 5'(size), 2'($urandom)});
		if (kind == PKT_TAIL) begin
			repeat ($urandom_range(1, 3)) begin
				fill_random();
				pick = $urandom_range(3);
				case (pick)
					0: begin
						ctrl = {1'b1, 5'd0, 2'($urandom)};
					end
					1: begin
						ctrl = {1'b1, 5'($urandom_range(SEG_BYTES + 1, 31)), 2'($urandom)};
					end
					2: begin
						ctrl = {1'b0, gen_next[4:0], 2'($urandom)};
						gen_next++;
					end
					default: begin
						ctrl = 8'($urandom);
					end
				endcase
				send_segment(ctrl);
			end
		end
	endtask

	initial begin
		int dice;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: clear with all ones, extreme data bytes, frame zero
		send_item(1'b1, 8'hFF);
		for (int i = 0; i < SEG_BYTES; i++) begin
			send_item(1'b0, (i % 2 == 1) ? 8'hFF : 8'h00);
		end
		send_item(1'b0, 8'h03);

		// long packet, many frames in a row
		run_packet(PKT_LONG);

		while (items_sent < ITEM_TARGET) begin
			dice = $urandom_range(99);
			if (dice < 55) begin
				run_packet(PKT_GOOD);
			end else if (dice < 70) begin
				run_packet(PKT_BAD_CRC);
			end else if (dice < 80) begin
				run_packet(PKT_SEQ);
			end else if (dice < 90) begin
				run_packet(PKT_TAIL);
			end else begin
				run_packet(PKT_NOISE);
			end
		end
		item_valid <= 1'b0;

		while (tracker.pending_reports.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
		if (tracker.failures == 0 && tracker.pending_reports.size() == 0) begin
			$display("PASS packet_segment_reassembly_crc_check");
		end else begin
			$display("FAIL packet_segment_reassembly_crc_check");
		end
		$finish;
	end

endmodule
